// ===== hdl/gshe_pkg.sv =====
// gshe_pkg: shared widths, register indexes, reset values, hat codes and
// the configuration bundle type for the stick conditioner.
// No dependencies.
`timescale 1ns / 1ps
package gshe_pkg;

  localparam int AXIS_W      = 8;
  localparam int DZ_W        = 7;
  localparam int GAIN_W      = 11;
  localparam int HAT_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  // reciprocal of (128 - deadzone), rounded up, scaled by 2^RECIP_K
  localparam int RECIP_K     = 21;
  localparam int RECIP_W     = RECIP_K + 1;
  // pm*128*recip >> 21 == pm*recip >> 14
  localparam int RECIP_SHIFT = RECIP_K - 7;
  localparam int DZ_DEPTH    = 1 << DZ_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_GAIN  = 2'd2;

  localparam logic [DZ_W-1:0]   DEADZONE_RST     = 7'd11;
  localparam logic              SCALE_ENABLE_RST = 1'b1;
  localparam logic [GAIN_W-1:0] RADIUS_GAIN_RST  = 11'd256;

  localparam logic [HAT_W-1:0] HAT_UP         = 4'd0;
  localparam logic [HAT_W-1:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [HAT_W-1:0] HAT_RIGHT      = 4'd2;
  localparam logic [HAT_W-1:0] HAT_DOWN_RIGHT = 4'd3;
  localparam logic [HAT_W-1:0] HAT_DOWN       = 4'd4;
  localparam logic [HAT_W-1:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [HAT_W-1:0] HAT_LEFT       = 4'd6;
  localparam logic [HAT_W-1:0] HAT_UP_LEFT    = 4'd7;
  localparam logic [HAT_W-1:0] HAT_CENTERED   = 4'd8;

  typedef struct packed {
    logic [DZ_W-1:0]    deadzone;
    logic               scale_enable;
    logic [GAIN_W-1:0]  radius_gain;
    logic [RECIP_W-1:0] recip;
  } gshe_cfg_t;

endpackage

// ===== hdl/gamepad_stick_deadzone_hat_encoder.sv =====
// Gamepad stick conditioner and hat encoder, top level.
// Uses gshe_pkg, gshe_cfg, gshe_lane (x4) and gshe_hat.
//
// Usage:
//  - Input: drive the four stick axes and d-pad lines with start high; the
//    beat is taken at a rising edge where start is high and busy is low.
//    busy is only high during reset, so a beat can enter every cycle.
//  - Output: each beat yields one result, shown with out_strobe high for
//    exactly one cycle once it has passed the stage 1, stage 2 and output
//    registers. The receiver cannot stall; results are never held back.
//  - Throughput 1 beat per cycle: stage 1 removes the deadzone, stage 2
//    rescales by a reciprocal multiply, stage 3 applies the radius gain
//    and lands in the output register.
//  - Configuration: cfg_we writes register cfg_index (0 deadzone,
//    1 scale_enable, 2 radius_gain) from cfg_data; other indexes are
//    ignored. Write only while no beat is in flight.
//  - Reset (rst_n low, synchronous) restores deadzone 11, scaling on and
//    gain 256, and clears the in-flight strobes.
`timescale 1ns / 1ps
module gamepad_stick_deadzone_hat_encoder import gshe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [AXIS_W-1:0]     in_left_x,
  input  logic [AXIS_W-1:0]     in_left_y,
  input  logic [AXIS_W-1:0]     in_right_x,
  input  logic [AXIS_W-1:0]     in_right_y,
  input  logic                  in_pad_left,
  input  logic                  in_pad_right,
  input  logic                  in_pad_down,
  input  logic                  in_pad_up,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_strobe,
  output logic [AXIS_W-1:0]     out_lx,
  output logic [AXIS_W-1:0]     out_ly,
  output logic [AXIS_W-1:0]     out_rx,
  output logic [AXIS_W-1:0]     out_ry,
  output logic [HAT_W-1:0]      out_hat_code
);

  gshe_cfg_t cfg;

  // four axis lanes side by side
  logic [AXIS_W-1:0] lane_raw [4];
  logic [AXIS_W-1:0] lane_val [4];
  logic [HAT_W-1:0]  hat;

  // beat tracking: one bit per pipeline stage
  logic       busy_r;
  logic [2:0] vld_r, vld_nxt;
  logic       accept;

  // merged result register
  logic [AXIS_W-1:0] lx_r, ly_r, rx_r, ry_r;
  logic [HAT_W-1:0]  hat_r;

  gshe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign lane_raw[0] = in_left_x;
  assign lane_raw[1] = in_left_y;
  assign lane_raw[2] = in_right_x;
  assign lane_raw[3] = in_right_y;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    gshe_lane u_lane (
      .clk   (clk),
      .cfg   (cfg),
      .raw   (lane_raw[i]),
      .value (lane_val[i])
    );
  end

  gshe_hat u_hat (
    .clk       (clk),
    .pad_left  (in_pad_left),
    .pad_right (in_pad_right),
    .pad_down  (in_pad_down),
    .pad_up    (in_pad_up),
    .hat       (hat)
  );

  assign accept  = start && !busy_r;
  assign vld_nxt = {vld_r[1:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
    end
  end

  // merge: Y axes inverted (255 - v is a bitwise complement)
  always_ff @(posedge clk) begin
    lx_r  <= lane_val[0];
    ly_r  <= ~lane_val[1];
    rx_r  <= lane_val[2];
    ry_r  <= ~lane_val[3];
    hat_r <= hat;
  end

  assign busy         = busy_r;
  assign out_strobe   = vld_r[2];
  assign out_lx       = lx_r;
  assign out_ly       = ly_r;
  assign out_rx       = rx_r;
  assign out_ry       = ry_r;
  assign out_hat_code = hat_r;

endmodule

// ===== hdl/gshe_cfg.sv =====
// gshe_cfg: configuration registers plus the registered reciprocal of
// (128 - deadzone) used by the lanes' rescale multiply. Depends on gshe_pkg.
`timescale 1ns / 1ps
module gshe_cfg import gshe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output gshe_cfg_t             cfg
);

  logic [DZ_W-1:0]    deadzone_r,     deadzone_nxt;
  logic               scale_enable_r, scale_enable_nxt;
  logic [GAIN_W-1:0]  radius_gain_r,  radius_gain_nxt;
  logic [RECIP_W-1:0] recip_r,        recip_nxt;
  logic [RECIP_W-1:0] recip_tbl [DZ_DEPTH];

  for (genvar i = 0; i < DZ_DEPTH; i++) begin : g_recip
    localparam int unsigned DivC   = DZ_DEPTH - i;
    localparam int unsigned RecipC = ((1 << RECIP_K) + DivC - 1) / DivC;
    assign recip_tbl[i] = RECIP_W'(RecipC);
  end

  always_comb begin
    deadzone_nxt     = deadzone_r;
    scale_enable_nxt = scale_enable_r;
    radius_gain_nxt  = radius_gain_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEADZONE:     deadzone_nxt     = cfg_data[DZ_W-1:0];
        CFG_SCALE_ENABLE: scale_enable_nxt = cfg_data[0];
        CFG_RADIUS_GAIN:  radius_gain_nxt  = cfg_data[GAIN_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
    recip_nxt = recip_tbl[deadzone_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r     <= DEADZONE_RST;
      scale_enable_r <= SCALE_ENABLE_RST;
      radius_gain_r  <= RADIUS_GAIN_RST;
    end else begin
      deadzone_r     <= deadzone_nxt;
      scale_enable_r <= scale_enable_nxt;
      radius_gain_r  <= radius_gain_nxt;
    end
    recip_r <= recip_nxt;
  end

  assign cfg.deadzone     = deadzone_r;
  assign cfg.scale_enable = scale_enable_r;
  assign cfg.radius_gain  = radius_gain_r;
  assign cfg.recip        = recip_r;

endmodule

// ===== hdl/gshe_lane.sv =====
// gshe_lane: one axis conditioner, two register stages (deadzone, rescale)
// followed by the radius gain in front of the output register.
// Depends on gshe_pkg.
`timescale 1ns / 1ps
module gshe_lane import gshe_pkg::*; (
  input  logic              clk,
  input  gshe_cfg_t         cfg,
  input  logic [AXIS_W-1:0] raw,
  output logic [AXIS_W-1:0] value
);

  localparam int PROD_W = AXIS_W + RECIP_W;
  localparam int GPROD_W = AXIS_W + GAIN_W;

  // stage 1: deadzone
  logic [AXIS_W-1:0] mag;
  logic              dead;
  logic              s1_dead_r, s1_neg_r;
  logic [AXIS_W-1:0] s1_pm_r;

  // stage 2: rescale
  logic [PROD_W-1:0] prod;
  logic [AXIS_W-1:0] quo, scaled, mag2;
  logic              s2_neg_r;
  logic [AXIS_W-1:0] s2_mag_r;

  // stage 3: radius gain
  logic [GPROD_W-1:0] gprod;
  logic [6:0]         gmag;

  always_comb begin
    // offset magnitude from center, 1..128 below center
    mag  = raw[7] ? {1'b0, raw[6:0]} : (8'd128 - raw);
    dead = (mag <= {1'b0, cfg.deadzone});
  end

  always_ff @(posedge clk) begin
    s1_dead_r <= dead;
    s1_neg_r  <= ~raw[7];
    s1_pm_r   <= mag - {1'b0, cfg.deadzone};
  end

  always_comb begin
    prod   = PROD_W'(s1_pm_r) * PROD_W'(cfg.recip);
    quo    = prod[RECIP_SHIFT +: AXIS_W];
    // only the positive side clamps; full negative deflection keeps 128
    scaled = (quo[7] && !s1_neg_r) ? 8'd127 : quo;
    mag2   = cfg.scale_enable ? scaled : s1_pm_r;
    if (s1_dead_r) mag2 = '0;
  end

  always_ff @(posedge clk) begin
    s2_neg_r <= s1_neg_r;
    s2_mag_r <= mag2;
  end

  always_comb begin
    gprod = GPROD_W'(s2_mag_r) * GPROD_W'(cfg.radius_gain);
    gmag  = (gprod[GPROD_W-1:14] != '0) ? 7'd127 : gprod[13:7];
    value = s2_neg_r ? (8'd128 - {1'b0, gmag}) : (8'd128 + {1'b0, gmag});
  end

endmodule

// ===== hdl/gshe_hat.sv =====
// gshe_hat: d-pad to hat code encoder, registered twice to line up with
// the axis lanes. Depends on gshe_pkg.
`timescale 1ns / 1ps
module gshe_hat import gshe_pkg::*; (
  input  logic             clk,
  input  logic             pad_left,
  input  logic             pad_right,
  input  logic             pad_down,
  input  logic             pad_up,
  output logic [HAT_W-1:0] hat
);

  logic [HAT_W-1:0] code;
  logic [HAT_W-1:0] s1_hat_r, s2_hat_r;

  always_comb begin
    if (pad_right && !pad_left)
      code = pad_up ? HAT_UP_RIGHT : (pad_down ? HAT_DOWN_RIGHT : HAT_RIGHT);
    else if (pad_left && !pad_right)
      code = pad_up ? HAT_UP_LEFT : (pad_down ? HAT_DOWN_LEFT : HAT_LEFT);
    else if (pad_down && !pad_up)
      code = HAT_DOWN;
    else if (pad_up && !pad_down)
      code = HAT_UP;
    else
      code = HAT_CENTERED;
  end

  always_ff @(posedge clk) begin
    s1_hat_r <= code;
    s2_hat_r <= s1_hat_r;
  end

  assign hat = s2_hat_r;

endmodule

// ===== hdl/gshe_checker.sv =====
// gshe_checker: port-level assertions for the stick conditioner, bound to
// the top level. Depends on gshe_pkg and gamepad_stick_deadzone_hat_encoder.
`timescale 1ns / 1ps
module gshe_checker import gshe_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_pad_left,
  input logic              in_pad_right,
  input logic              in_pad_down,
  input logic              in_pad_up,
  input logic              out_strobe,
  input logic [AXIS_W-1:0] out_lx,
  input logic [AXIS_W-1:0] out_ly,
  input logic [HAT_W-1:0]  out_hat_code
);

  // every accepted beat produces a strobed result
  a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("accepted beat gave no result");

  // no result without a beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!(start && !busy)) |-> ##3 !out_strobe)
    else $error("result without accepted beat");

  // gain clamp keeps out_lx above 0 and out_ly below 255
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_lx != 8'd0 && out_ly != 8'd255))
    else $error("axis output out of clamp range");

  // up without down, with left and right equal (both or neither), encodes as up
  a_hat_up: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_pad_up && !in_pad_down && (in_pad_left == in_pad_right))
      |-> ##3 (out_hat_code == HAT_UP))
    else $error("up press not encoded as up");

endmodule

bind gamepad_stick_deadzone_hat_encoder gshe_checker u_gshe_checker (.*);

// ===== tb/gamepad_stick_deadzone_hat_encoder_tb.sv =====
// Self-checking testbench for the gamepad stick conditioner and hat encoder.
// Depends on gshe_pkg and the gamepad_stick_deadzone_hat_encoder top level only.
// Directed corner beats, then constrained-by-hand random beats under several register settings.
`timescale 1ns / 1ps
module gamepad_stick_deadzone_hat_encoder_tb;
  import gshe_pkg::*;

  localparam int CLK_HALF      = 4;     // 8 ns period
  localparam int RESET_CYCLES  = 7;
  localparam int PIPE_LATENCY  = 3;     // accept edge to strobe
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 5;
  localparam int STALL_LIMIT   = 2000;  // cycles with no beat in or out
  localparam int BEATS_PER_SET = 58;

  // index 3 has no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // sender idle rate per phase, in percent
  localparam int GAP_LIGHT = 8;
  localparam int GAP_HEAVY = 51;
  localparam int GAP_NONE  = 0;

  typedef enum logic [1:0] {
    CMD_SAMPLE,   // one input beat
    CMD_DRAIN,    // hold off until every report is back, then settle
    CMD_REG_WR    // single config register write, only when idle
  } host_cmd_kind_t;

  typedef struct {
    host_cmd_kind_t          kind;
    int unsigned             gap_pct;
    logic [AXIS_W-1:0]       lx, ly, rx, ry;
    logic [3:0]              pads;     // {left, right, down, up}
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
  } host_cmd_t;

  typedef struct {
    logic [AXIS_W-1:0] lx, ly, rx, ry;
    logic [HAT_W-1:0]  hat;
  } pad_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [AXIS_W-1:0] in_left_x = '0;
  logic [AXIS_W-1:0] in_left_y = '0;
  logic [AXIS_W-1:0] in_right_x = '0;
  logic [AXIS_W-1:0] in_right_y = '0;
  logic in_pad_left = 1'b0;
  logic in_pad_right = 1'b0;
  logic in_pad_down = 1'b0;
  logic in_pad_up = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_strobe;
  logic [AXIS_W-1:0] out_lx, out_ly, out_rx, out_ry;
  logic [HAT_W-1:0]  out_hat_code;

  gamepad_stick_deadzone_hat_encoder i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_left_x    (in_left_x),
    .in_left_y    (in_left_y),
    .in_right_x   (in_right_x),
    .in_right_y   (in_right_y),
    .in_pad_left  (in_pad_left),
    .in_pad_right (in_pad_right),
    .in_pad_down  (in_pad_down),
    .in_pad_up    (in_pad_up),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_strobe   (out_strobe),
    .out_lx       (out_lx),
    .out_ly       (out_ly),
    .out_rx       (out_rx),
    .out_ry       (out_ry),
    .out_hat_code (out_hat_code)
  );

  always #(CLK_HALF) clk = ~clk;

  host_cmd_t   host_cmds[$];         // pending work for the driver
  pad_report_t expected_reports[$];  // predicted reports, oldest first
  int unsigned fail_count = 0;
  logic        beat_taken = 1'b0;    // start was accepted at the last rising edge
  int unsigned settle_left = 0;

  // Shadow of the block's registers, updated on the same edge as the RTL.
  logic [DZ_W-1:0]   dz_shadow    = DEADZONE_RST;
  logic              scale_shadow = SCALE_ENABLE_RST;
  logic [GAIN_W-1:0] gain_shadow  = RADIUS_GAIN_RST;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One axis: signed offset from center, deadzone removal, optional
  // full-range rescale, then radius gain with a +/-127 magnitude clamp.
  // All quotients truncate toward zero, as the RTL must.
  function automatic logic [AXIS_W-1:0] condition_axis(logic [AXIS_W-1:0] raw);
    int offs, mag, dz, rem, rem_mag, scaled, dev, gained;
    offs = int'(raw) - 128;
    dz   = int'(dz_shadow);
    mag  = (offs < 0) ? -offs : offs;
    if (mag <= dz) begin
      dev = 0;
    end else begin
      rem = (offs < 0) ? offs + dz : offs - dz;
      if (scale_shadow) begin
        rem_mag = (rem < 0) ? -rem : rem;
        scaled  = (rem_mag * 128) / (128 - dz);
        if (rem < 0) scaled = -scaled;
        // only the positive side can overshoot; -128 stays representable
        if (scaled > 127) scaled = 127;
        dev = scaled;
      end else begin
        dev = rem;
      end
    end
    gained = (((dev < 0) ? -dev : dev) * int'(gain_shadow)) / 128;
    if (gained > 127) gained = 127;
    if (dev < 0) gained = -gained;
    return AXIS_W'(gained + 128);
  endfunction

  // Opposing lines cancel; with one horizontal line held, up beats down.
  function automatic logic [HAT_W-1:0] encode_hat(logic l, logic r, logic d, logic u);
    if (r && !l) return u ? HAT_UP_RIGHT : (d ? HAT_DOWN_RIGHT : HAT_RIGHT);
    if (l && !r) return u ? HAT_UP_LEFT : (d ? HAT_DOWN_LEFT : HAT_LEFT);
    if (d && !u) return HAT_DOWN;
    if (u && !d) return HAT_UP;
    return HAT_CENTERED;
  endfunction

  // Y axes come out mirrored as 255 minus the conditioned value.
  function automatic pad_report_t predict_report();
    pad_report_t rpt;
    rpt.lx  = condition_axis(in_left_x);
    rpt.ly  = AXIS_W'(255 - int'(condition_axis(in_left_y)));
    rpt.rx  = condition_axis(in_right_x);
    rpt.ry  = AXIS_W'(255 - int'(condition_axis(in_right_y)));
    rpt.hat = encode_hat(in_pad_left, in_pad_right, in_pad_down, in_pad_up);
    return rpt;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs move on the falling edge. A held beat stays put until the
  // rising edge has taken it; register writes and drains wait for an empty
  // pipe so no beat ever sees a setting change mid-flight.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_proc
    host_cmd_t cmd;
    logic      nxt_start;
    logic      nxt_we;
    nxt_start = start;
    nxt_we    = 1'b0;
    if (rst_n && !(start && !beat_taken)) begin
      nxt_start = 1'b0;
      if (settle_left != 0) begin
        settle_left--;
      end else if (host_cmds.size() != 0) begin
        cmd = host_cmds[0];
        case (cmd.kind)
          CMD_SAMPLE: begin
            if ($urandom_range(99) >= cmd.gap_pct) begin
              in_left_x    <= cmd.lx;
              in_left_y    <= cmd.ly;
              in_right_x   <= cmd.rx;
              in_right_y   <= cmd.ry;
              {in_pad_left, in_pad_right, in_pad_down, in_pad_up} <= cmd.pads;
              nxt_start = 1'b1;
              void'(host_cmds.pop_front());
            end
          end
          CMD_DRAIN: begin
            if (expected_reports.size() == 0) begin
              settle_left = PIPE_LATENCY;
              void'(host_cmds.pop_front());
            end
          end
          CMD_REG_WR: begin
            if (expected_reports.size() == 0) begin
              cfg_index <= cmd.reg_idx;
              cfg_data  <= cmd.reg_val;
              nxt_we = 1'b1;
              void'(host_cmds.pop_front());
            end
          end
          default: ;
        endcase
      end
    end
    if (!rst_n) nxt_start = 1'b0;
    start  <= nxt_start;
    cfg_we <= nxt_we;
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge check a strobed report against the oldest
  // prediction, predict any beat accepted on this edge, then track writes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    pad_report_t want;
    if (!rst_n) begin
      beat_taken <= 1'b0;
    end else begin
      if (out_strobe) begin
        if (expected_reports.size() == 0) begin
          $error("report strobed with none outstanding: lx %0d ly %0d rx %0d ry %0d hat %0d",
                 out_lx, out_ly, out_rx, out_ry, out_hat_code);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("out_lx", want.lx, out_lx);
          check_field("out_ly", want.ly, out_ly);
          check_field("out_rx", want.rx, out_rx);
          check_field("out_ry", want.ry, out_ry);
          check_field("out_hat_code", want.hat, out_hat_code);
        end
      end
      if (start && !busy) expected_reports.push_back(predict_report());
      beat_taken <= start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEADZONE:     dz_shadow    = cfg_data[DZ_W-1:0];
          CFG_SCALE_ENABLE: scale_shadow = cfg_data[0];
          CFG_RADIUS_GAIN:  gain_shadow  = cfg_data[GAIN_W-1:0];
          default: ;  // unmapped index: dropped
        endcase
      end
    end
  end

  // Watchdog: a run that stops moving beats in either direction is dead.
  int unsigned stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d reports outstanding",
               STALL_LIMIT, expected_reports.size());
      $display("** gamepad_stick_deadzone_hat_encoder: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_sample(logic [AXIS_W-1:0] lx, logic [AXIS_W-1:0] ly,
                             logic [AXIS_W-1:0] rx, logic [AXIS_W-1:0] ry,
                             logic [3:0] pads, int unsigned gap);
    host_cmd_t cmd;
    cmd = '{kind: CMD_SAMPLE, gap_pct: gap, lx: lx, ly: ly, rx: rx, ry: ry,
            pads: pads, reg_idx: '0, reg_val: '0};
    host_cmds.push_back(cmd);
  endtask

  task automatic push_reg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    host_cmd_t cmd;
    cmd = '{kind: CMD_REG_WR, gap_pct: 0, lx: '0, ly: '0, rx: '0, ry: '0,
            pads: '0, reg_idx: idx, reg_val: CFG_DATA_W'(val)};
    host_cmds.push_back(cmd);
  endtask

  task automatic push_drain();
    host_cmd_t cmd;
    cmd = '{kind: CMD_DRAIN, gap_pct: 0, lx: '0, ly: '0, rx: '0, ry: '0,
            pads: '0, reg_idx: '0, reg_val: '0};
    host_cmds.push_back(cmd);
  endtask

  // Axis values weighted toward the deadzone edges and the rails; the rest
  // is uniform over the full byte.
  function automatic logic [AXIS_W-1:0] pick_axis(int dz);
    int sel, v;
    sel = $urandom_range(99);
    if (sel < 30) begin
      v = dz + int'($urandom_range(3)) - 1;
      v = $urandom_range(1) ? 128 + v : 128 - v;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
    end else if (sel < 45) begin
      case ($urandom_range(6))
        0: v = 0;
        1: v = 1;
        2: v = 127;
        3: v = 128;
        4: v = 129;
        5: v = 254;
        default: v = 255;
      endcase
    end else begin
      v = $urandom_range(255);
    end
    return AXIS_W'(v);
  endfunction

  initial begin : stim_proc
    // deadzone 11 sits at raw 117..139; 116 and 140 are the first live counts
    logic [AXIS_W-1:0] corner_vals[12] = '{0, 255, 128, 117, 116, 139, 140,
                                           127, 129, 1, 254, 64};
    int setting_dz[9]   = '{0, 0, 127, 127, 64, 5, 1, 0, 0};
    int setting_scl[9]  = '{0, 1, 1, 0, 1, 0, 1, 0, 0};
    int setting_gain[9] = '{128, 1024, 2047, 0, 300, 1024, 129, 0, 0};
    int unsigned gap;

    // the last two settings are drawn at random; gain now and then past 1024
    for (int k = 7; k < 9; k++) begin
      setting_dz[k]   = $urandom_range(127);
      setting_scl[k]  = $urandom_range(1);
      setting_gain[k] = ($urandom_range(9) < 7) ? $urandom_range(1024)
                                                 : $urandom_range(2047, 1025);
    end

    // Directed at reset values: every d-pad combination, axes at the rails,
    // center and both sides of each deadzone edge.
    for (int i = 0; i < 16; i++)
      push_sample(corner_vals[i % 12], corner_vals[(i + 3) % 12],
                  corner_vals[(i + 6) % 12], corner_vals[(i + 9) % 12],
                  4'(i), GAP_LIGHT);

    // an unmapped index must leave all three registers alone
    push_reg_write(CFG_UNUSED_IDX, $urandom_range(2047));
    push_sample(8'd0, 8'd255, 8'd140, 8'd116, 4'b0101, GAP_LIGHT);

    for (int k = 0; k < 9; k++) begin
      // three phases of sender idling: light, heavy, none
      gap = (k < 3) ? GAP_LIGHT : (k < 6) ? GAP_HEAVY : GAP_NONE;
      push_reg_write(CFG_DEADZONE, setting_dz[k]);
      push_reg_write(CFG_SCALE_ENABLE, setting_scl[k]);
      push_reg_write(CFG_RADIUS_GAIN, setting_gain[k]);
      // full deflection both ways and dead center under each setting
      push_sample(8'd0, 8'd0, 8'd0, 8'd0, 4'($urandom_range(15)), gap);
      push_sample(8'd255, 8'd255, 8'd255, 8'd255, 4'($urandom_range(15)), gap);
      push_sample(8'd128, 8'd128, 8'd128, 8'd128, 4'($urandom_range(15)), gap);
      for (int n = 0; n < BEATS_PER_SET; n++) begin
        // sender backs off mid-set until the pipe has fully drained
        if (n == BEATS_PER_SET / 2) push_drain();
        push_sample(pick_axis(setting_dz[k]), pick_axis(setting_dz[k]),
                    pick_axis(setting_dz[k]), pick_axis(setting_dz[k]),
                    4'($urandom_range(15)), gap);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (host_cmds.size() != 0 || start || expected_reports.size() != 0)
      @(posedge clk);
    // any late or stray strobe still gets caught by the monitor here
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("** gamepad_stick_deadzone_hat_encoder: PASSED **");
    end else begin
      $display("** gamepad_stick_deadzone_hat_encoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gshe_pkg.sv
hdl/gshe_cfg.sv
hdl/gshe_lane.sv
hdl/gshe_hat.sv
hdl/gamepad_stick_deadzone_hat_encoder.sv
hdl/gshe_checker.sv
tb/gamepad_stick_deadzone_hat_encoder_tb.sv
